/* rtl/core/smtc_pkg.sv */
// Shared constants and interface structs for the square mean threshold counter.
package smtc_pkg;

    localparam int VALUE_W    = 32;  // input element port width
    localparam int COUNT_W    = 17;  // result count width, wraps on overflow
    localparam int THR_W      = 32;  // threshold register width
    localparam int SIZE_W     = 7;   // rows / cols size field width in cfg_data
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

    // loader -> top / walker
    typedef struct packed {
        logic last_acc;  // last element of the matrix transferred in
        logic walk_go;   // last element written to the table
    } ld_stat_t;

    // square evaluator -> walker
    typedef struct packed {
        logic done;      // result valid this cycle
        logic qual;      // square mean reaches threshold
    } ev_stat_t;

endpackage

/* rtl/core/square_mean_threshold_counter_top.sv */
// Top level: config registers, summed-area table RAM, loader, walker, evaluator, result register.
// Load: one element per cycle; each element's table write comes in the cycle after its transfer.
// Walk: after the last element, the cells are swept one by one with square probes; a cell
//   takes at most about 2*log2(side)+2 probes, all serialized on the table's single read port.
// One matrix at a time: input is held off from its last element through its walk.
// Reset: aresetn synchronous, active low; clears control and config (rows, cols = 64 or the
//   maximum, threshold 0). Table contents stay undefined: every entry used is written first.
module square_mean_threshold_counter_top #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [smtc_pkg::VALUE_W-1:0]      s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [smtc_pkg::COUNT_W-1:0]      m_count,
    input  logic                              cfg_we,
    input  logic [smtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smtc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RB       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW       = RB + CB;
    localparam int TW       = VALUE_BITS + RB + CB;
    localparam int LW       = ((RB > CB) ? RB : CB) + 1;
    localparam int DEPTH    = 1 << AW;
    localparam int ROWS_RST = (MAX_ROWS < 64) ? MAX_ROWS : 64;
    localparam int COLS_RST = (MAX_COLS < 64) ? MAX_COLS : 64;

    // effective (clamped) matrix size and threshold
    logic [RB:0]                   rows_reg;
    logic [CB:0]                   cols_reg;
    logic [smtc_pkg::THR_W-1:0]    thr_reg;
    logic [smtc_pkg::SIZE_W-1:0]   size_in;
    logic [RB:0]                   rows_clamp;
    logic [CB:0]                   cols_clamp;
    logic                          cfg_restart;

    // summed-area table
    logic [TW-1:0]                 tab_mem [DEPTH];
    logic [TW-1:0]                 tab_rdata_reg;
    logic [AW-1:0]                 tab_raddr;

    logic                          busy_reg;
    logic                          m_valid_reg;
    logic [smtc_pkg::COUNT_W-1:0]  m_count_reg;

    logic                          accept;
    smtc_pkg::ld_stat_t            ld_stat;
    logic [AW-1:0]                 ld_raddr;
    logic                          ld_we;
    logic [AW-1:0]                 ld_waddr;
    logic [TW-1:0]                 ld_wdata;

    smtc_pkg::ev_stat_t            ev_stat;
    logic                          ev_start;
    logic [RB-1:0]                 ev_x;
    logic [CB-1:0]                 ev_y;
    logic [LW-1:0]                 ev_len;
    logic [AW-1:0]                 ev_raddr;

    logic                          out_free;
    logic                          res_valid;
    logic [smtc_pkg::COUNT_W-1:0]  res_count;
    logic                          res_fire;

    // ---------------------------------------------------------------
    // Configuration: clamp sizes into [1, MAX]; a size write restarts loading
    // ---------------------------------------------------------------
    assign size_in = cfg_data[smtc_pkg::SIZE_W-1:0];

    always_comb begin
        if (size_in == '0) begin
            rows_clamp = (RB+1)'(1);
        end else if (int'(size_in) > MAX_ROWS) begin
            rows_clamp = (RB+1)'(MAX_ROWS);
        end else begin
            rows_clamp = (RB+1)'(size_in);
        end
        if (size_in == '0) begin
            cols_clamp = (CB+1)'(1);
        end else if (int'(size_in) > MAX_COLS) begin
            cols_clamp = (CB+1)'(MAX_COLS);
        end else begin
            cols_clamp = (CB+1)'(size_in);
        end
    end

    assign cfg_restart = cfg_we &&
        (cfg_index == smtc_pkg::REG_ROWS || cfg_index == smtc_pkg::REG_COLS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= (RB+1)'(ROWS_RST);
            cols_reg <= (CB+1)'(COLS_RST);
            thr_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                smtc_pkg::REG_ROWS:      rows_reg <= rows_clamp;
                smtc_pkg::REG_COLS:      cols_reg <= cols_clamp;
                smtc_pkg::REG_THRESHOLD: thr_reg  <= cfg_data[smtc_pkg::THR_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input side: hold off transfers from the last element until the result
    // has moved into the output register
    // ---------------------------------------------------------------
    assign s_ready = !busy_reg;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (ld_stat.last_acc) begin
            busy_reg <= 1'b1;
        end else if (res_fire) begin
            busy_reg <= 1'b0;
        end
    end

    smtc_loader #(
        .RB (RB),
        .CB (CB),
        .VB (VALUE_BITS),
        .TW (TW)
    ) u_loader (
        .aclk    (aclk),
        .aresetn (aresetn),
        .restart (cfg_restart),
        .nr      (rows_reg),
        .nc      (cols_reg),
        .accept  (accept),
        .value   (s_value),
        .raddr   (ld_raddr),
        .rdata   (tab_rdata_reg),
        .we      (ld_we),
        .waddr   (ld_waddr),
        .wdata   (ld_wdata),
        .stat    (ld_stat)
    );

    // ---------------------------------------------------------------
    // Table memory: one write port (loader), one read port shared by the
    // loader while filling and the evaluator while walking; read data
    // registered, old data on a same-address collision
    // ---------------------------------------------------------------
    assign tab_raddr = busy_reg ? ev_raddr : ld_raddr;

    always_ff @(posedge aclk) begin
        if (ld_we) begin
            tab_mem[ld_waddr] <= ld_wdata;
        end
        tab_rdata_reg <= tab_mem[tab_raddr];
    end

    // ---------------------------------------------------------------
    // Walk: cell sweep with bisection, one square probe at a time
    // ---------------------------------------------------------------
    smtc_walker #(
        .RB (RB),
        .CB (CB)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .nr        (rows_reg),
        .nc        (cols_reg),
        .go        (ld_stat.walk_go),
        .out_free  (out_free),
        .ev_stat   (ev_stat),
        .ev_start  (ev_start),
        .ev_x      (ev_x),
        .ev_y      (ev_y),
        .ev_len    (ev_len),
        .res_valid (res_valid),
        .res_count (res_count)
    );

    smtc_eval #(
        .RB (RB),
        .CB (CB),
        .TW (TW)
    ) u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ev_start),
        .x       (ev_x),
        .y       (ev_y),
        .len     (ev_len),
        .thr     (thr_reg),
        .raddr   (ev_raddr),
        .rdata   (tab_rdata_reg),
        .stat    (ev_stat)
    );

    // ---------------------------------------------------------------
    // Output register: advance a finished count when the slot is empty or
    // its current transfer completes this cycle
    // ---------------------------------------------------------------
    assign out_free = !m_valid_reg || m_ready;
    assign res_fire = res_valid && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_fire) begin
            m_count_reg <= res_count;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_count = m_count_reg;

    a_closed_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_stat.last_acc |=> !s_ready)
        else $error("input open after last element of matrix");

    a_walk_while_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        ld_stat.walk_go |-> busy_reg)
        else $error("walk started while input still open");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_fire |=> m_valid && (m_count == $past(res_count)))
        else $error("finished count not captured in output register");

endmodule

/* rtl/core/smtc_loader.sv */
// Loader: builds the summed-area table from the row-major element stream.
module smtc_loader #(
    parameter int RB = 6,
    parameter int CB = 6,
    parameter int VB = 32,
    parameter int TW = 44
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           restart,
    input  logic [RB:0]                    nr,
    input  logic [CB:0]                    nc,
    input  logic                           accept,
    input  logic [smtc_pkg::VALUE_W-1:0]   value,
    output logic [RB+CB-1:0]               raddr,
    input  logic [TW-1:0]                  rdata,
    output logic                           we,
    output logic [RB+CB-1:0]               waddr,
    output logic [TW-1:0]                  wdata,
    output smtc_pkg::ld_stat_t             stat
);

    localparam int RSW = VB + CB;
    localparam int AW  = RB + CB;

    logic [RB-1:0]  row_reg, row_next;
    logic [CB-1:0]  col_reg, col_next;
    logic [RSW-1:0] rsum_reg, rsum_next;

    logic           st_valid_reg;
    logic [AW-1:0]  st_addr_reg;
    logic [RSW-1:0] st_rsum_reg;
    logic           st_above_reg;
    logic           st_last_reg;
    logic           fwd_reg;
    logic [TW-1:0]  wq_reg;

    logic [VB-1:0]  v;
    logic [RSW-1:0] rsum_sum;
    logic           col_last;
    logic           row_last;
    logic [TW-1:0]  above;

    assign v        = VB'(value);
    assign rsum_sum = rsum_reg + RSW'(v);
    assign col_last = (CB'(0) + (CB+1)'(col_reg) + (CB+1)'(1)) == nc;
    assign row_last = ((RB+1)'(row_reg) + (RB+1)'(1)) == nr;
    assign raddr    = {row_reg - RB'(1), col_reg};

    always_comb begin
        row_next  = row_reg;
        col_next  = col_reg;
        rsum_next = rsum_reg;
        if (restart) begin
            row_next  = '0;
            col_next  = '0;
            rsum_next = '0;
        end else if (accept) begin
            if (col_last) begin
                col_next  = '0;
                rsum_next = '0;
                row_next  = row_last ? '0 : row_reg + RB'(1);
            end else begin
                col_next  = col_reg + CB'(1);
                rsum_next = rsum_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            rsum_reg     <= '0;
            st_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            rsum_reg     <= rsum_next;
            st_valid_reg <= accept;
            fwd_reg      <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge aclk) begin
        st_addr_reg  <= {row_reg, col_reg};
        st_rsum_reg  <= rsum_sum;
        st_above_reg <= (row_reg != '0);
        st_last_reg  <= col_last && row_last;
        wq_reg       <= wdata;
    end

    // forward the entry written at the same edge the read was issued
    assign above = fwd_reg ? wq_reg : rdata;
    assign we    = st_valid_reg;
    assign waddr = st_addr_reg;
    assign wdata = (st_above_reg ? above : '0) + TW'(st_rsum_reg);

    assign stat.last_acc = accept && col_last && row_last;
    assign stat.walk_go  = st_valid_reg && st_last_reg;

endmodule

/* rtl/core/smtc_eval.sv */
// Square evaluator: four table reads, square sum, threshold * side^2 compare.
module smtc_eval #(
    parameter int RB = 6,
    parameter int CB = 6,
    parameter int TW = 44
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [RB-1:0]                 x,
    input  logic [CB-1:0]                 y,
    input  logic [((RB > CB) ? RB : CB):0] len,
    input  logic [smtc_pkg::THR_W-1:0]    thr,
    output logic [RB+CB-1:0]              raddr,
    input  logic [TW-1:0]                 rdata,
    output smtc_pkg::ev_stat_t            stat
);

    localparam int LW = ((RB > CB) ? RB : CB) + 1;
    localparam int NW = smtc_pkg::THR_W + 2 * LW;
    localparam int CW = (TW > NW) ? TW : NW;

    typedef enum logic [6:0] {
        E_IDLE = 7'b0000001,
        E_RA   = 7'b0000010,
        E_RB   = 7'b0000100,
        E_RC   = 7'b0001000,
        E_RD   = 7'b0010000,
        E_SUM  = 7'b0100000,
        E_CMP  = 7'b1000000
    } ev_ph_t;

    ev_ph_t          ph_reg, ph_next;
    logic [RB-1:0]   x_reg;
    logic [CB-1:0]   y_reg;
    logic [LW-1:0]   len_reg;
    logic [2*LW-1:0] sq_reg;
    logic [NW-1:0]   need_reg;
    logic [TW-1:0]   acc_reg, acc_next;

    logic [RB-1:0]   x2, xm1;
    logic [CB-1:0]   y2, ym1;
    logic            xnz, ynz;

    assign x2  = RB'((LW+1)'(x_reg) + (LW+1)'(len_reg) - (LW+1)'(1));
    assign y2  = CB'((LW+1)'(y_reg) + (LW+1)'(len_reg) - (LW+1)'(1));
    assign xm1 = x_reg - RB'(1);
    assign ym1 = y_reg - CB'(1);
    assign xnz = (x_reg != '0);
    assign ynz = (y_reg != '0);

    always_comb begin
        case (ph_reg)
            E_RA:    raddr = {x2, y2};
            E_RB:    raddr = {xm1, y2};
            E_RC:    raddr = {x2, ym1};
            default: raddr = {xm1, ym1};
        endcase
    end

    always_comb begin
        ph_next  = ph_reg;
        acc_next = acc_reg;
        case (ph_reg)
            E_IDLE: if (start) ph_next = E_RA;
            E_RA:   ph_next = E_RB;
            E_RB: begin
                acc_next = rdata;
                ph_next  = E_RC;
            end
            E_RC: begin
                acc_next = acc_reg - (xnz ? rdata : '0);
                ph_next  = E_RD;
            end
            E_RD: begin
                acc_next = acc_reg - (ynz ? rdata : '0);
                ph_next  = E_SUM;
            end
            E_SUM: begin
                acc_next = acc_reg + ((xnz && ynz) ? rdata : '0);
                ph_next  = E_CMP;
            end
            E_CMP:   ph_next = start ? E_RA : E_IDLE;
            default: ph_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= E_IDLE;
        end else begin
            ph_reg <= ph_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= x;
            y_reg   <= y;
            len_reg <= len;
        end
        sq_reg   <= len_reg * len_reg;
        need_reg <= NW'(thr) * NW'(sq_reg);
        acc_reg  <= acc_next;
    end

    assign stat.done = (ph_reg == E_CMP);
    assign stat.qual = CW'(acc_reg) >= CW'(need_reg);

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> (ph_reg == E_IDLE || ph_reg == E_CMP))
        else $error("square evaluation restarted while busy");

endmodule

/* rtl/core/smtc_walker.sv */
// Walker: sweeps every cell, bisects the smallest qualifying side, sums counts.
module smtc_walker #(
    parameter int RB = 6,
    parameter int CB = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [RB:0]                     nr,
    input  logic [CB:0]                     nc,
    input  logic                            go,
    input  logic                            out_free,
    input  smtc_pkg::ev_stat_t              ev_stat,
    output logic                            ev_start,
    output logic [RB-1:0]                   ev_x,
    output logic [CB-1:0]                   ev_y,
    output logic [((RB > CB) ? RB : CB):0]  ev_len,
    output logic                            res_valid,
    output logic [smtc_pkg::COUNT_W-1:0]    res_count
);

    localparam int LW = ((RB > CB) ? RB : CB) + 1;

    typedef enum logic [4:0] {
        W_IDLE = 5'b00001,
        W_CELL = 5'b00010,
        W_STEP = 5'b00100,
        W_EVAL = 5'b01000,
        W_DONE = 5'b10000
    } walk_state_t;

    typedef enum logic [1:0] {
        K_LO  = 2'd0,   // final check of lo
        K_HI  = 2'd1,   // final check of hi
        K_MID = 2'd2,   // probe of mid
        K_MM1 = 2'd3    // probe of mid - 1
    } probe_t;

    walk_state_t                  state_reg, state_next;
    probe_t                       kind_reg, kind_next;
    logic [RB-1:0]                i_reg, i_next;
    logic [CB-1:0]                j_reg, j_next;
    logic [LW-1:0]                side_reg, side_next;
    logic [LW-1:0]                lo_reg, lo_next;
    logic [LW-1:0]                hi_reg, hi_next;
    logic [LW-1:0]                mid_reg, mid_next;
    logic [smtc_pkg::COUNT_W-1:0] total_reg, total_next;

    logic [LW-1:0] da, db, mid_calc, addv;
    logic [LW:0]   lohi;
    logic          adv;
    logic          j_last, i_last;

    assign da       = LW'(nr) - LW'(i_reg);
    assign db       = LW'(nc) - LW'(j_reg);
    assign lohi     = (LW+1)'(lo_reg) + (LW+1)'(hi_reg);
    assign mid_calc = lohi[LW:1];
    assign j_last   = ((CB+1)'(j_reg) + (CB+1)'(1)) == nc;
    assign i_last   = ((RB+1)'(i_reg) + (RB+1)'(1)) == nr;

    assign ev_x      = i_reg;
    assign ev_y      = j_reg;
    assign res_count = total_reg;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        side_next  = side_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        total_next = total_reg;
        ev_start   = 1'b0;
        ev_len     = lo_reg;
        res_valid  = 1'b0;
        adv        = 1'b0;
        addv       = '0;

        case (state_reg)
            W_IDLE: begin
                if (go) begin
                    i_next     = '0;
                    j_next     = '0;
                    total_next = '0;
                    state_next = W_CELL;
                end
            end
            W_CELL: begin
                side_next  = (da < db) ? da : db;
                lo_next    = LW'(1);
                hi_next    = (da < db) ? da : db;
                state_next = W_STEP;
            end
            W_STEP: begin
                ev_start   = 1'b1;
                state_next = W_EVAL;
                if ((hi_reg - lo_reg) <= LW'(1)) begin
                    ev_len    = lo_reg;
                    kind_next = K_LO;
                end else begin
                    ev_len    = mid_calc;
                    mid_next  = mid_calc;
                    kind_next = K_MID;
                end
            end
            W_EVAL: begin
                if (ev_stat.done) begin
                    case (kind_reg)
                        K_LO: begin
                            if (ev_stat.qual) begin
                                adv  = 1'b1;
                                addv = side_reg - lo_reg + LW'(1);
                            end else begin
                                ev_start  = 1'b1;
                                ev_len    = hi_reg;
                                kind_next = K_HI;
                            end
                        end
                        K_HI: begin
                            adv  = 1'b1;
                            addv = ev_stat.qual ? side_reg - hi_reg + LW'(1) : '0;
                        end
                        K_MID: begin
                            if (ev_stat.qual) begin
                                ev_start  = 1'b1;
                                ev_len    = mid_reg - LW'(1);
                                kind_next = K_MM1;
                            end else begin
                                lo_next    = mid_reg;
                                state_next = W_STEP;
                            end
                        end
                        K_MM1: begin
                            if (!ev_stat.qual) begin
                                adv  = 1'b1;
                                addv = side_reg - mid_reg + LW'(1);
                            end else begin
                                hi_next    = mid_reg;
                                state_next = W_STEP;
                            end
                        end
                        default: state_next = W_IDLE;
                    endcase
                end
            end
            W_DONE: begin
                res_valid = 1'b1;
                if (out_free) state_next = W_IDLE;
            end
            default: state_next = W_IDLE;
        endcase

        // close the cell: add its count and advance row-major
        if (adv) begin
            total_next = total_reg + smtc_pkg::COUNT_W'(addv);
            if (j_last) begin
                j_next = '0;
                if (i_last) begin
                    state_next = W_DONE;
                end else begin
                    i_next     = i_reg + RB'(1);
                    state_next = W_CELL;
                end
            end else begin
                j_next     = j_reg + CB'(1);
                state_next = W_CELL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        side_reg <= side_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
    end

    a_done_in_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_stat.done |-> state_reg == W_EVAL)
        else $error("evaluator result arrived outside the probe wait");

endmodule
